FILE: rtl/mdu_pkg.sv
// Shared types and constants of the 68000 multiply and divide unit.
`default_nettype none

package mdu_pkg;

  // Width of the dividend, which is also the number of divide cells.
  localparam int unsigned DividendWidth = 32;
  localparam int unsigned WordWidth     = 16;
  localparam int unsigned FlagWidth     = 4;

  // Condition code bit positions.
  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagV = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [1:0] {
    FuncDivu = 2'd0,
    FuncDivs = 2'd1,
    FuncMulu = 2'd2,
    FuncMuls = 2'd3
  } mdu_func_e;

  // One instruction as it travels down the chain of cells.
  typedef struct packed {
    mdu_func_e                  func;
    logic [FlagWidth-1:0]       flags;
    logic                       zero_div;
    logic                       neg_q;
    logic                       neg_r;
    logic [WordWidth-1:0]       divisor;
    logic [WordWidth-1:0]       rem;
    logic [DividendWidth-1:0]   dq;
  } mdu_beat_t;

  function automatic logic is_div(mdu_func_e f);
    return (f == FuncDivu) || (f == FuncDivs);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mdu_prep.sv
// Entry stage: operand magnitudes for the divide and the full multiply.
`default_nettype none

module mdu_prep (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire mdu_pkg::mdu_func_e   func_i,
  input  wire logic [31:0]          dest_i,
  input  wire logic [15:0]          src_i,
  input  wire logic [3:0]           flags_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output mdu_pkg::mdu_beat_t        beat_o
);

  logic               valid_q;
  mdu_pkg::mdu_beat_t beat_q;
  mdu_pkg::mdu_beat_t beat_d;

  logic               div_op;
  logic               dneg;
  logic               sneg;
  logic               msgn;
  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [33:0] prod;
  logic [31:0]        dmag;
  logic [15:0]        smag;

  always_comb begin
    div_op = mdu_pkg::is_div(func_i);
    dneg   = (func_i == mdu_pkg::FuncDivs) && dest_i[31];
    sneg   = (func_i == mdu_pkg::FuncDivs) && src_i[15];
    dmag   = dneg ? (~dest_i + 32'd1) : dest_i;
    smag   = sneg ? (~src_i + 16'd1) : src_i;
    msgn   = (func_i == mdu_pkg::FuncMuls);
    mul_a  = $signed({msgn & dest_i[15], dest_i[15:0]});
    mul_b  = $signed({msgn & src_i[15], src_i});
    prod   = mul_a * mul_b;

    beat_d.func     = func_i;
    beat_d.flags    = flags_i;
    beat_d.zero_div = div_op && (src_i == 16'd0);
    beat_d.neg_q    = dneg ^ sneg;
    beat_d.neg_r    = dneg;
    beat_d.divisor  = smag;
    beat_d.rem      = '0;
    beat_d.dq       = div_op ? dmag : prod[31:0];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

FILE: rtl/mdu_cell.sv
// One restoring divide cell: retires one quotient bit per beat.
`default_nettype none

module mdu_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire mdu_pkg::mdu_beat_t beat_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output mdu_pkg::mdu_beat_t      beat_o
);

  logic               valid_q;
  mdu_pkg::mdu_beat_t beat_q;
  mdu_pkg::mdu_beat_t beat_d;

  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  always_comb begin
    trial  = {beat_i.rem, beat_i.dq[31]};
    diff   = trial - {1'b0, beat_i.divisor};
    ge     = trial >= {1'b0, beat_i.divisor};
    beat_d = beat_i;
    // Multiplies ride through untouched with their product in dq.
    if (mdu_pkg::is_div(beat_i.func)) begin
      beat_d.rem = ge ? diff[15:0] : trial[15:0];
      beat_d.dq  = {beat_i.dq[30:0], ge};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

FILE: rtl/mdu_final.sv
// Exit stage: sign correction, overflow check, flags and the output register.
`default_nettype none

module mdu_final (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire mdu_pkg::mdu_beat_t beat_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic [31:0]             result_o,
  output logic                    write_back_o,
  output logic [3:0]              flags_o,
  output logic                    trap_o
);

  logic        valid_q;
  logic [31:0] result_q;
  logic        wb_q;
  logic [3:0]  flags_q;
  logic        trap_q;

  logic [31:0] result_d;
  logic        wb_d;
  logic [3:0]  flags_d;
  logic        trap_d;

  logic [15:0] quot;
  logic [15:0] rem;
  logic        ovf;

  always_comb begin
    quot = beat_i.neg_q ? (~beat_i.dq[15:0] + 16'd1) : beat_i.dq[15:0];
    rem  = beat_i.neg_r ? (~beat_i.rem + 16'd1) : beat_i.rem;
    if (beat_i.func == mdu_pkg::FuncDivs) begin
      // A negative quotient may reach -32768, a positive one only 32767.
      ovf = beat_i.neg_q ? (beat_i.dq > 32'd32768) : (beat_i.dq > 32'd32767);
    end else begin
      ovf = |beat_i.dq[31:16];
    end

    result_d = '0;
    wb_d     = 1'b0;
    flags_d  = beat_i.flags;
    trap_d   = 1'b0;
    if (!mdu_pkg::is_div(beat_i.func)) begin
      result_d               = beat_i.dq;
      wb_d                   = 1'b1;
      flags_d                = '0;
      flags_d[mdu_pkg::FlagN] = beat_i.dq[31];
      flags_d[mdu_pkg::FlagZ] = (beat_i.dq == 32'd0);
    end else if (beat_i.zero_div) begin
      trap_d = 1'b1;
    end else if (ovf) begin
      flags_d[mdu_pkg::FlagV] = 1'b1;
    end else begin
      result_d               = {rem, quot};
      wb_d                   = 1'b1;
      flags_d                = '0;
      flags_d[mdu_pkg::FlagN] = quot[15];
      flags_d[mdu_pkg::FlagZ] = (quot == 16'd0);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_d;
      wb_q     <= wb_d;
      flags_q  <= flags_d;
      trap_q   <= trap_d;
    end
  end

  assign valid_o      = valid_q;
  assign result_o     = result_q;
  assign write_back_o = wb_q;
  assign flags_o      = flags_q;
  assign trap_o       = trap_q;

endmodule

`default_nettype wire

FILE: rtl/m68k_multiply_divide_unit.sv
// Path: an accepted input beat passes the entry stage, 32 divide cells and the output
// register on its way to its output beat; multiplies take the same path so order holds.
// Throughput: one instruction per cycle while the output accepts; each stage takes a new beat when it is
// empty or its content moves on, so bubbles collapse under output backpressure.
// Reset clears every stage valid bit at once; payload registers are not reset.
`default_nettype none

module m68k_multiply_divide_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] dest_value, [47:32] src_word, [51:48] flags_in, [55:52] zero
  input  wire logic [55:0] s_axis_tdata,
  // [1:0] func
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] result, [32] write_back, [36:33] flags_out, [37] zero_divide_trap,
  // [39:38] zero
  output logic [39:0]      m_axis_tdata
);

  localparam int unsigned Cells = mdu_pkg::DividendWidth;

  logic               valid_c [Cells+1];
  logic               ready_c [Cells+1];
  mdu_pkg::mdu_beat_t beat_c  [Cells+1];

  logic               fin_ready;
  logic [31:0]        result;
  logic               write_back;
  logic [3:0]         flags_out;
  logic               trap;

  mdu_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .func_i  (mdu_pkg::mdu_func_e'(s_axis_tuser)),
    .dest_i  (s_axis_tdata[31:0]),
    .src_i   (s_axis_tdata[47:32]),
    .flags_i (s_axis_tdata[51:48]),
    .valid_o (valid_c[0]),
    .ready_i (ready_c[0]),
    .beat_o  (beat_c[0])
  );

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    mdu_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[i]),
      .ready_o (ready_c[i]),
      .beat_i  (beat_c[i]),
      .valid_o (valid_c[i+1]),
      .ready_i (ready_c[i+1]),
      .beat_o  (beat_c[i+1])
    );
  end

  assign ready_c[Cells] = fin_ready;

  mdu_final u_final (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_c[Cells]),
    .ready_o      (fin_ready),
    .beat_i       (beat_c[Cells]),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .result_o     (result),
    .write_back_o (write_back),
    .flags_o      (flags_out),
    .trap_o       (trap)
  );

  assign m_axis_tdata = {2'b00, trap, flags_out, write_back, result};

  a_trap_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && trap |-> !write_back && (result == 32'd0))
    else $error("zero divide trap with a register write");

  a_ovf_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && write_back |-> !flags_out[mdu_pkg::FlagV] && !flags_out[mdu_pkg::FlagC])
    else $error("written result with V or C set");

  a_empty_entry_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_c[0] |-> s_axis_tready)
    else $error("entry stage empty but input not ready");

  a_chain_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("chain stalled while the output is drained");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the 68000 multiply and divide unit.
`default_nettype none

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  // One result beat, packed as on m_axis_tdata.
  typedef struct packed {
    logic [1:0]  pad;
    logic        trap;
    logic [3:0]  flags;
    logic        wb;
    logic [31:0] value;
  } mdu_result_t;

  typedef struct {
    mdu_pkg::mdu_func_e func;
    logic [31:0]        dest;
    logic [15:0]        src;
    logic [3:0]         flags;
    bit                 typed;
    mdu_result_t        want;
  } op_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  mdu_result_t pending_results[$];
  op_row_t     directed_ops[$];
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          n_checked = 0;
  int          n_div = 0;
  int          n_mul = 0;
  int          n_trap = 0;
  int          n_ovf = 0;

  m68k_multiply_divide_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("Timeout with %0d results outstanding.", pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic mdu_result_t predict_mdu(mdu_pkg::mdu_func_e f, logic [31:0] d,
                                              logic [15:0] s, logic [3:0] fl);
    mdu_result_t r;
    logic [31:0] uq;
    logic [31:0] prod;
    logic [15:0] quot;
    logic [15:0] rem;
    longint      sq;
    longint      sr;
    int          ma;
    int          mb;
    bit          ovf;
    r = '0;
    r.flags = fl;
    if (mdu_pkg::is_div(f)) begin
      if (s == 16'h0000) begin
        r.trap = 1'b1;
      end else begin
        if (f == mdu_pkg::FuncDivu) begin
          uq = d / {16'h0000, s};
          ovf = (uq > 32'h0000_FFFF);
          quot = uq[15:0];
          rem = 16'(d % {16'h0000, s});
        end else begin
          // Truncating divide: the remainder follows the dividend's sign.
          sq = longint'($signed(d)) / longint'($signed(s));
          sr = longint'($signed(d)) % longint'($signed(s));
          ovf = (sq < -32768) || (sq > 32767);
          quot = sq[15:0];
          rem = sr[15:0];
        end
        if (ovf) begin
          r.flags[mdu_pkg::FlagV] = 1'b1;
        end else begin
          r.value = {rem, quot};
          r.wb = 1'b1;
          r.flags = '0;
          r.flags[mdu_pkg::FlagN] = quot[15];
          r.flags[mdu_pkg::FlagZ] = (quot == 16'h0000);
        end
      end
    end else begin
      if (f == mdu_pkg::FuncMulu) begin
        prod = {16'h0000, d[15:0]} * {16'h0000, s};
      end else begin
        ma = int'($signed(d[15:0]));
        mb = int'($signed(s));
        prod = ma * mb;
      end
      r.value = prod;
      r.wb = 1'b1;
      r.flags = '0;
      r.flags[mdu_pkg::FlagN] = prod[31];
      r.flags[mdu_pkg::FlagZ] = (prod == 32'h0);
    end
    return r;
  endfunction

  function automatic op_row_t mk_op(mdu_pkg::mdu_func_e f, logic [31:0] d, logic [15:0] s,
                                    logic [3:0] fl, bit typed = 1'b0,
                                    logic [31:0] value = '0, logic wb = 1'b0,
                                    logic [3:0] fo = '0, logic trap = 1'b0);
    op_row_t row;
    row.func = f;
    row.dest = d;
    row.src = s;
    row.flags = fl;
    row.typed = typed;
    row.want = '{pad: 2'b00, trap: trap, flags: fo, wb: wb, value: value};
    return row;
  endfunction

  // Handshake is decided at the falling edge, where both sides are stable.
  task automatic send_op(input mdu_pkg::mdu_func_e f, input logic [31:0] d,
                         input logic [15:0] s, input logic [3:0] fl,
                         input mdu_result_t want);
    bit taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'h0, fl, s, d};
    s_axis_tuser <= f;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    pending_results.push_back(want);
  endtask

  task automatic send_random_op();
    mdu_pkg::mdu_func_e f;
    logic [31:0]        d;
    logic [15:0]        s;
    logic [3:0]         fl;
    int                 shift;
    f = mdu_pkg::mdu_func_e'($urandom_range(0, 3));
    d = $urandom;
    s = 16'($urandom_range(0, 16'hFFFF));
    fl = 4'($urandom_range(0, 15));
    shift = $urandom_range(0, 31);
    if (mdu_pkg::is_div(f)) begin
      // Shrink most dividends so that quotients mostly fit.
      if ($urandom_range(0, 3) != 0) begin
        d = (f == mdu_pkg::FuncDivs) ? 32'($signed(d) >>> shift) : (d >> shift);
      end
      if ($urandom_range(0, 15) == 0) begin
        s = 16'h0000;
      end
    end
    send_op(f, d, s, fl, predict_mdu(f, d, s, fl));
  endtask

  always @(negedge clk_i) begin
    mdu_result_t got;
    mdu_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result beat %h at cycle %0d.", m_axis_tdata, cycle_count);
        end
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.trap) n_trap++;
        else if (!want.wb) n_ovf++;
        if (got.value !== want.value || got.wb !== want.wb || got.flags !== want.flags ||
            got.trap !== want.trap || got.pad !== want.pad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch on result %0d: value %h/%h wb %b/%b flags %b/%b trap %b/%b",
                     n_checked, want.value, got.value, want.wb, got.wb,
                     want.flags, got.flags, want.trap, got.trap);
          end
        end
      end
    end
  end

  initial begin
    int idle_set[4];
    int stall_set[4];
    op_row_t row;
    idle_set = '{0, 50, 0, 36};
    stall_set = '{0, 0, 50, 36};
    directed_ops = '{
      mk_op(mdu_pkg::FuncDivu, 32'h0000_0000, 16'hFFFF, 4'hF,
            1'b1, 32'h0, 1'b1, 4'h4, 1'b0),
      mk_op(mdu_pkg::FuncDivu, 32'hFFFF_FFFF, 16'h0000, 4'hA,
            1'b1, 32'h0, 1'b0, 4'hA, 1'b1),
      mk_op(mdu_pkg::FuncDivs, 32'h8000_0000, 16'h0000, 4'h5,
            1'b1, 32'h0, 1'b0, 4'h5, 1'b1),
      mk_op(mdu_pkg::FuncDivu, 32'hFFFF_FFFF, 16'h0001, 4'h0,
            1'b1, 32'h0, 1'b0, 4'h2, 1'b0),
      mk_op(mdu_pkg::FuncDivu, 32'hFFFF_FFFF, 16'hFFFF, 4'hD,
            1'b1, 32'h0, 1'b0, 4'hF, 1'b0),
      mk_op(mdu_pkg::FuncDivs, 32'h8000_0000, 16'hFFFF, 4'h8,
            1'b1, 32'h0, 1'b0, 4'hA, 1'b0),
      mk_op(mdu_pkg::FuncDivs, 32'h0000_8000, 16'h0001, 4'h1,
            1'b1, 32'h0, 1'b0, 4'h3, 1'b0),
      mk_op(mdu_pkg::FuncMulu, 32'hABCD_FFFF, 16'hFFFF, 4'h7,
            1'b1, 32'hFFFE_0001, 1'b1, 4'h8, 1'b0),
      mk_op(mdu_pkg::FuncMulu, 32'hFFFF_0000, 16'hFFFF, 4'hF,
            1'b1, 32'h0, 1'b1, 4'h4, 1'b0),
      mk_op(mdu_pkg::FuncMuls, 32'h0000_8000, 16'h8000, 4'hF,
            1'b1, 32'h4000_0000, 1'b1, 4'h0, 1'b0),
      mk_op(mdu_pkg::FuncDivu, 32'h0000_FFFF, 16'h0001, 4'h0),
      mk_op(mdu_pkg::FuncDivu, 32'hFFFE_FFFF, 16'hFFFF, 4'hF),
      mk_op(mdu_pkg::FuncDivs, 32'hFFFF_8000, 16'h0001, 4'h0),
      mk_op(mdu_pkg::FuncDivs, 32'h0000_7FFF, 16'h0001, 4'hF),
      mk_op(mdu_pkg::FuncDivs, 32'hFFFF_FFF9, 16'h0002, 4'h0),
      mk_op(mdu_pkg::FuncDivs, 32'h0000_0007, 16'hFFFE, 4'h0),
      mk_op(mdu_pkg::FuncDivs, 32'hFFFF_FFF9, 16'hFFFE, 4'h0),
      mk_op(mdu_pkg::FuncDivs, 32'h7FFF_FFFF, 16'h7FFF, 4'h6),
      mk_op(mdu_pkg::FuncDivu, 32'h0000_0007, 16'h0002, 4'h9),
      mk_op(mdu_pkg::FuncDivu, 32'h1234_5678, 16'h1234, 4'h0),
      mk_op(mdu_pkg::FuncMuls, 32'h0000_8000, 16'h7FFF, 4'h0),
      mk_op(mdu_pkg::FuncMuls, 32'hFFFF_FFFF, 16'h0001, 4'h0),
      mk_op(mdu_pkg::FuncMuls, 32'h1234_0000, 16'h8001, 4'hB),
      mk_op(mdu_pkg::FuncMulu, 32'h0000_0000, 16'h0000, 4'h0)
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_ops[i]) begin
      row = directed_ops[i];
      send_op(row.func, row.dest, row.src, row.flags,
              row.typed ? row.want : predict_mdu(row.func, row.dest, row.src, row.flags));
      if (mdu_pkg::is_div(row.func)) n_div++;
      else n_mul++;
    end

    for (int phase = 0; phase < 4; phase++) begin
      // Hold the sender off until the pipeline has drained completely.
      s_axis_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
      idle_pct = idle_set[phase];
      stall_pct = stall_set[phase];
      for (int k = 0; k < 108; k++) begin
        send_random_op();
        if (mdu_pkg::is_div(mdu_pkg::mdu_func_e'(s_axis_tuser))) n_div++;
        else n_mul++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Checked %0d results: %0d divides with %0d quotient overflows and %0d zero",
             n_checked, n_div, n_ovf, n_trap);
    $display("divisors, %0d multiplies, under four source and sink pressure phases.", n_mul);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatches, pending_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
